// ----- rtl/ivs_pkg.sv -----
// Shared constants, types and a helper function of the indexed value store.
`default_nettype none
package ivs_pkg;

   // Store geometry.
   localparam int ENTRIES   = 64;
   localparam int ADDR_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int LANES_MAX = 16;
   localparam int CNT_W     = $clog2(LANES_MAX + 1);

   // Field widths.
   localparam int FUNC_W  = 2;
   localparam int KEY_W   = 32;
   localparam int DATA_W  = 32;
   localparam int LANES_W = 5;
   localparam int LANES_RESET = 16;

   // Stream packing.
   localparam int REQ_TDATA_W = KEY_W + DATA_W;
   localparam int RSP_FIELD_W = KEY_W + DATA_W + 2;
   localparam int RSP_TDATA_W = ((RSP_FIELD_W + 7) / 8) * 8;

   // Operation codes.
   localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_STORE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_EVICT = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_NOP   = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic match;
      logic access;
      logic ev_pick;
      logic load_out;
   } ivs_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic              out_free;
      logic              ev_done;
      logic              overflow;
   } ivs_stat_type;

   // Address of the lowest set bit; zero when no bit is set.
   function automatic logic [ADDR_W-1:0] lowest_set(input logic [ENTRIES-1:0] vec);
      logic [ADDR_W-1:0] idx;
      idx = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (vec[i]) idx = ADDR_W'(i);
      end
      return idx;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/ivs_ram.sv -----
// Generic single write port RAM with one registered read port.
`default_nettype none
module ivs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                                        clock,
   input  wire logic                                        wr_en,
   input  wire logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0]  wr_addr,
   input  wire logic [WIDTH-1:0]                            wr_data,
   input  wire logic                                        rd_en,
   input  wire logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0]  rd_addr,
   output logic      [WIDTH-1:0]                            rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
   end

   // Registered read port; the data holds while no read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// ----- rtl/ivs_datapath.sv -----
// Datapath: key match array, valid bits, key and data RAMs, output register.
`default_nettype none
module ivs_datapath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire ivs_pkg::ivs_cmd_type          cmd,
   output ivs_pkg::ivs_stat_type              stat,
   input  wire logic [ivs_pkg::FUNC_W-1:0]    req_func,
   input  wire logic [ivs_pkg::KEY_W-1:0]     req_index,
   input  wire logic [ivs_pkg::DATA_W-1:0]    req_value,
   input  wire logic                          csr_write,
   input  wire logic [ivs_pkg::LANES_W-1:0]   csr_lanes,
   input  wire logic                          rsp_ready,
   output logic                               rsp_valid,
   output logic [ivs_pkg::FUNC_W-1:0]         rsp_kind,
   output logic [ivs_pkg::KEY_W-1:0]          rsp_key,
   output logic [ivs_pkg::DATA_W-1:0]         rsp_data,
   output logic                               rsp_hit,
   output logic                               rsp_overflow,
   output logic                               rsp_last
);
   import ivs_pkg::*;

   // Captured request.
   logic [FUNC_W-1:0] func_ff;
   logic [KEY_W-1:0]  index_ff;
   logic [DATA_W-1:0] value_ff;

   // Store state.
   logic [KEY_W-1:0]   cam_key_ff [ENTRIES];
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [ENTRIES-1:0] match_ff;
   logic               overflow_ff, overflow_in;
   logic [LANES_W-1:0] lanes_ff;

   // Evict progress.
   logic [CNT_W-1:0] ev_cnt_ff, ev_cnt_in;
   logic             ev_hit_ff, ev_hit_in;
   logic             ev_last_ff, ev_last_in;
   logic [CNT_W-1:0] ev_limit;

   // Output register.
   logic              out_valid_ff, out_valid_in;
   logic [FUNC_W-1:0] out_kind_ff;
   logic [KEY_W-1:0]  out_key_ff;
   logic [DATA_W-1:0] out_data_ff;
   logic              out_hit_ff, out_ovf_ff, out_last_ff;

   // Derived selection signals.
   logic               any_match, any_free, any_valid;
   logic [ADDR_W-1:0]  match_addr, free_addr, ev_addr;
   logic [ENTRIES-1:0] ev_onehot, free_onehot;
   logic               is_load, is_store;
   logic               alloc, data_we;
   logic               key_rd_en, data_rd_en;
   logic [ADDR_W-1:0]  data_rd_addr, data_wr_addr;
   logic [KEY_W-1:0]   key_rdata;
   logic [DATA_W-1:0]  data_rdata;

   assign is_load     = (func_ff == FUNC_LOAD);
   assign is_store    = (func_ff == FUNC_STORE);
   assign any_match   = |match_ff;
   assign any_free    = ~&valid_ff;
   assign any_valid   = |valid_ff;
   assign match_addr  = lowest_set(match_ff);
   assign free_addr   = lowest_set(~valid_ff);
   assign ev_addr     = lowest_set(valid_ff);
   assign ev_onehot   = ENTRIES'(1) << ev_addr;
   assign free_onehot = ENTRIES'(1) << free_addr;

   assign alloc        = cmd.access && is_store && !any_match && any_free;
   assign data_we      = cmd.access && is_store && (any_match || any_free);
   assign data_wr_addr = any_match ? match_addr : free_addr;
   assign data_rd_en   = (cmd.access && is_load) || cmd.ev_pick;
   assign data_rd_addr = cmd.ev_pick ? ev_addr : match_addr;
   assign key_rd_en    = cmd.ev_pick;

   // Request capture.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff  <= req_func;
         index_ff <= req_index;
         value_ff <= req_value;
      end
   end

   // Parallel key compare against every valid entry.
   always_ff @(posedge clock) begin
      if (cmd.match) begin
         for (int i = 0; i < ENTRIES; i++) begin
            match_ff[i] <= valid_ff[i] && (cam_key_ff[i] == index_ff);
         end
      end
   end

   // Key copy used for matching, written when a store allocates a slot.
   always_ff @(posedge clock) begin
      for (int i = 0; i < ENTRIES; i++) begin
         if (alloc && free_onehot[i]) cam_key_ff[i] <= index_ff;
      end
   end

   // Valid bits: set on allocation, cleared as an entry is evicted.
   always_comb begin
      valid_in = valid_ff;
      if (alloc) valid_in = valid_ff | free_onehot;
      if (cmd.ev_pick && any_valid) valid_in = valid_ff & ~ev_onehot;
   end

   assign overflow_in = overflow_ff || (cmd.access && is_store && !any_match && !any_free);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         overflow_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         overflow_ff <= overflow_in;
      end
   end

   // Lanes register with its effective limit.
   always_ff @(posedge clock) begin
      if (reset) begin
         lanes_ff <= LANES_W'(LANES_RESET);
      end else if (csr_write) begin
         lanes_ff <= csr_lanes;
      end
   end

   always_comb begin
      if (lanes_ff == '0) begin
         ev_limit = CNT_W'(1);
      end else if (int'(lanes_ff) > LANES_MAX) begin
         ev_limit = CNT_W'(LANES_MAX);
      end else begin
         ev_limit = CNT_W'(lanes_ff);
      end
   end

   // Evict bookkeeping: count of emitted entries and end of the run.
   always_comb begin
      ev_cnt_in  = ev_cnt_ff;
      ev_hit_in  = ev_hit_ff;
      ev_last_in = ev_last_ff;
      if (cmd.capture) begin
         ev_cnt_in = '0;
      end else if (cmd.ev_pick) begin
         ev_hit_in  = any_valid;
         ev_cnt_in  = ev_cnt_ff + CNT_W'(1);
         ev_last_in = ((ev_cnt_ff + CNT_W'(1)) == ev_limit) ||
                      ((valid_ff & ~ev_onehot) == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ev_cnt_ff  <= '0;
         ev_hit_ff  <= 1'b0;
         ev_last_ff <= 1'b0;
      end else begin
         ev_cnt_ff  <= ev_cnt_in;
         ev_hit_ff  <= ev_hit_in;
         ev_last_ff <= ev_last_in;
      end
   end

   // Key and data storage.
   ivs_ram #(.WIDTH(KEY_W), .DEPTH(ENTRIES)) u_key_ram (
      .clock   (clock),
      .wr_en   (alloc),
      .wr_addr (free_addr),
      .wr_data (index_ff),
      .rd_en   (key_rd_en),
      .rd_addr (ev_addr),
      .rd_data (key_rdata)
   );

   ivs_ram #(.WIDTH(DATA_W), .DEPTH(ENTRIES)) u_data_ram (
      .clock   (clock),
      .wr_en   (data_we),
      .wr_addr (data_wr_addr),
      .wr_data (value_ff),
      .rd_en   (data_rd_en),
      .rd_addr (data_rd_addr),
      .rd_data (data_rdata)
   );

   // Output register: loaded on command, emptied when the receiver takes it.
   assign out_valid_in = cmd.load_out ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_kind_ff <= func_ff;
         out_ovf_ff  <= overflow_ff;
         if (func_ff == FUNC_EVICT) begin
            out_key_ff  <= ev_hit_ff ? key_rdata : '0;
            out_data_ff <= ev_hit_ff ? data_rdata : '0;
            out_hit_ff  <= ev_hit_ff;
            out_last_ff <= ev_hit_ff ? ev_last_ff : 1'b1;
         end else begin
            out_key_ff  <= index_ff;
            out_data_ff <= (is_load && any_match) ? data_rdata : '0;
            out_hit_ff  <= is_load && any_match;
            out_last_ff <= 1'b1;
         end
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_kind     = out_kind_ff;
   assign rsp_key      = out_key_ff;
   assign rsp_data     = out_data_ff;
   assign rsp_hit      = out_hit_ff;
   assign rsp_overflow = out_ovf_ff;
   assign rsp_last     = out_last_ff;

   // Status towards the controller.
   assign stat.func     = func_ff;
   assign stat.out_free = !out_valid_ff || rsp_ready;
   assign stat.ev_done  = !ev_hit_ff || ev_last_ff;
   assign stat.overflow = overflow_ff;
endmodule
`default_nettype wire

// ----- rtl/ivs_ctrl.sv -----
// Controller state machine sequencing loads, stores and evict runs.
`default_nettype none
module ivs_ctrl (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   input  wire logic [ivs_pkg::FUNC_W-1:0]    req_func,
   output logic                               req_ready,
   input  wire ivs_pkg::ivs_stat_type         stat,
   output ivs_pkg::ivs_cmd_type               cmd
);
   import ivs_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_MATCH  = 3'd1;
   localparam logic [2:0] S_ACCESS = 3'd2;
   localparam logic [2:0] S_RESULT = 3'd3;
   localparam logic [2:0] S_EVPICK = 3'd4;
   localparam logic [2:0] S_EVOUT  = 3'd5;

   logic [2:0] state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               unique case (req_func)
                  FUNC_LOAD, FUNC_STORE: state_in = S_MATCH;
                  FUNC_EVICT:            state_in = S_EVPICK;
                  default:               state_in = S_IDLE;
               endcase
            end
         end
         S_MATCH: begin
            cmd.match = 1'b1;
            state_in  = S_ACCESS;
         end
         S_ACCESS: begin
            cmd.access = 1'b1;
            state_in   = S_RESULT;
         end
         S_RESULT: begin
            if (stat.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_EVPICK: begin
            cmd.ev_pick = 1'b1;
            state_in    = S_EVOUT;
         end
         S_EVOUT: begin
            if (stat.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = stat.ev_done ? S_IDLE : S_EVPICK;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule
`default_nettype wire

// ----- rtl/indexed_value_store_core.sv -----
// Top level of the indexed value store: ports, controller, datapath, checks.
//
// A fully associative store of 64 (key, data) entries with valid bits.
// Items enter on the req_ stream: tuser is the operation (load, store,
// evict), tdata the index and the value. Results leave on the rsp_ stream,
// one per load or store, one per evicted entry (or a single empty one) for
// an evict; tlast marks the final result of an item. The lanes register,
// written on the csr_ channel, caps how many entries one evict removes.
// Items are worked on one at a time. A load or a store is captured at its
// accepting edge, then takes a parallel key compare, a RAM access or write
// and an output register load, after which the next item can be taken.
// For each result an evict picks the lowest valid entry with a registered
// RAM read, then loads the output register; the next item can be taken
// after its last result is loaded. req_tready is high whenever no item
// is in progress, even while a result waits in the output register; a
// stalled receiver holds the block in its result step. Reset clears the
// valid bits, the overflow flag and the output valid flag and sets lanes
// to 16; key and data RAMs are not cleared.
`default_nettype none
module indexed_value_store_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // Request stream.
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [ivs_pkg::REQ_TDATA_W-1:0]   req_tdata,  // index[31:0], value[63:32]
   input  wire logic [ivs_pkg::FUNC_W-1:0]        req_tuser,  // func[1:0]
   // Result stream.
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [ivs_pkg::RSP_TDATA_W-1:0]        rsp_tdata,  // key_out[31:0], data_out[63:32],
                                                              // hit[64], overflow[65], zeros
   output logic [ivs_pkg::FUNC_W-1:0]             rsp_tuser,  // kind[1:0]
   output logic                                   rsp_tlast,
   // Lanes register write channel.
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [ivs_pkg::LANES_W-1:0]       csr_data
);
   import ivs_pkg::*;

   ivs_cmd_type       cmd;
   ivs_stat_type      stat;
   logic [KEY_W-1:0]  rsp_key;
   logic [DATA_W-1:0] rsp_data;
   logic              rsp_hit, rsp_overflow;

   assign csr_ready = 1'b1;

   ivs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_func  (req_tuser),
      .req_ready (req_tready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ivs_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .req_func     (req_tuser),
      .req_index    (req_tdata[KEY_W-1:0]),
      .req_value    (req_tdata[KEY_W+DATA_W-1:KEY_W]),
      .csr_write    (csr_valid && csr_ready),
      .csr_lanes    (csr_data),
      .rsp_ready    (rsp_tready),
      .rsp_valid    (rsp_tvalid),
      .rsp_kind     (rsp_tuser),
      .rsp_key      (rsp_key),
      .rsp_data     (rsp_data),
      .rsp_hit      (rsp_hit),
      .rsp_overflow (rsp_overflow),
      .rsp_last     (rsp_tlast)
   );

   // Result packing, padded with zeros to whole bytes.
   assign rsp_tdata = RSP_TDATA_W'({rsp_overflow, rsp_hit, rsp_data, rsp_key});

   // The overflow flag is sticky until reset.
   a_overflow_sticky: assert property (@(posedge clock) disable iff (reset)
      !$fell(stat.overflow))
      else $error("overflow flag cleared without reset");

   // A working item blocks further items until it finishes.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tuser != FUNC_NOP)) |=> !req_tready)
      else $error("item accepted while another is in progress");

   // A load miss returns zero data.
   a_load_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == FUNC_LOAD) && !rsp_hit) |-> (rsp_data == '0))
      else $error("load miss carries non-zero data");

   // A store answers with exactly one plain result.
   a_store_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == FUNC_STORE)) |-> (rsp_tlast && !rsp_hit && (rsp_data == '0)))
      else $error("malformed store result");
endmodule
`default_nettype wire

// ----- verif/ivs_result_checker.sv -----
// Result checker of the indexed value store: predicts results from accepted items and compares.
`timescale 1ns / 1ps
module ivs_result_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [ivs_pkg::REQ_TDATA_W-1:0]  req_tdata,  // index[31:0], value[63:32]
   input  logic [ivs_pkg::FUNC_W-1:0]       req_tuser,  // func[1:0]
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [ivs_pkg::RSP_TDATA_W-1:0]  rsp_tdata,  // key_out[31:0], data_out[63:32],
                                                        // hit[64], overflow[65], zeros
   input  logic [ivs_pkg::FUNC_W-1:0]       rsp_tuser,  // kind[1:0]
   input  logic                             rsp_tlast,
   input  logic                             csr_valid,
   input  logic                             csr_ready,
   input  logic [ivs_pkg::LANES_W-1:0]      csr_data,
   output int                               fail_count,
   output int                               outstanding
);
   import ivs_pkg::*;

   // One result item as the block should present it.
   typedef struct packed {
      logic [FUNC_W-1:0] kind;
      logic [KEY_W-1:0]  key;
      logic [DATA_W-1:0] data;
      logic              hit;
      logic              overflow;
      logic              last;
   } store_result_type;

   // Shadow copy of the store contents, the sticky flag and the lanes register.
   logic [KEY_W-1:0]   shadow_key  [ENTRIES];
   logic [DATA_W-1:0]  shadow_data [ENTRIES];
   logic [ENTRIES-1:0] shadow_valid;
   logic               shadow_overflow;
   logic [LANES_W-1:0] shadow_lanes;

   // Results predicted but not yet seen on the result stream, oldest first.
   store_result_type awaited_results [$];

   initial begin
      fail_count  = 0;
      outstanding = 0;
   end

   // Lowest valid address holding the key, or -1 when none holds it.
   function automatic int match_slot(input logic [KEY_W-1:0] index);
      int a;
      match_slot = -1;
      for (a = ENTRIES - 1; a >= 0; a--) begin
         if (shadow_valid[a] && shadow_key[a] == index) match_slot = a;
      end
   endfunction

   // Appends one predicted result behind those already waiting.
   task automatic queue_result(input store_result_type res);
      awaited_results.insert(awaited_results.size(), res);
   endtask

   // Applies one accepted item to the shadow store and queues the results it causes.
   task automatic apply_request(input logic [FUNC_W-1:0] func, input logic [KEY_W-1:0] index,
                                input logic [DATA_W-1:0] value);
      int               a;
      int               n;
      int               slot;
      int               cap;
      int               taken;
      int               picked [LANES_MAX];
      store_result_type res;
      res = '0;
      res.kind = func;
      res.last = 1'b1;
      case (func)
         FUNC_LOAD: begin
            slot = match_slot(index);
            res.key = index;
            if (slot >= 0) begin
               res.data = shadow_data[slot];
               res.hit  = 1'b1;
            end
            res.overflow = shadow_overflow;
            queue_result(res);
         end
         FUNC_STORE: begin
            slot = match_slot(index);
            // Without a match the lowest free slot is taken; a full store only flags.
            if (slot < 0) begin
               for (a = ENTRIES - 1; a >= 0; a--) begin
                  if (!shadow_valid[a]) slot = a;
               end
               if (slot < 0) begin
                  shadow_overflow = 1'b1;
               end else begin
                  shadow_key[slot]   = index;
                  shadow_valid[slot] = 1'b1;
               end
            end
            if (slot >= 0) shadow_data[slot] = value;
            res.key      = index;
            res.overflow = shadow_overflow;
            queue_result(res);
         end
         FUNC_EVICT: begin
            // Zero lanes behaves as one, anything above the maximum saturates.
            if (shadow_lanes == 0) cap = 1;
            else if (shadow_lanes > LANES_MAX) cap = LANES_MAX;
            else cap = int'(shadow_lanes);
            taken = 0;
            for (a = 0; a < ENTRIES && taken < cap; a++) begin
               if (shadow_valid[a]) begin
                  picked[taken] = a;
                  taken++;
               end
            end
            // An empty store still answers with a single empty result.
            if (taken == 0) begin
               res.overflow = shadow_overflow;
               queue_result(res);
            end
            for (n = 0; n < taken; n++) begin
               res.key      = shadow_key[picked[n]];
               res.data     = shadow_data[picked[n]];
               res.hit      = 1'b1;
               res.overflow = shadow_overflow;
               res.last     = (n == taken - 1);
               shadow_valid[picked[n]] = 1'b0;
               queue_result(res);
            end
         end
         default: ;
      endcase
   endtask

   task automatic compare_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
         fail_count = fail_count + 1;
      end
   endtask

   // Results are checked before the same edge's item is predicted: no item can answer at once.
   always @(posedge clock) begin : monitor
      store_result_type want;
      if (reset) begin
         shadow_valid    = '0;
         shadow_overflow = 1'b0;
         shadow_lanes    = LANES_W'(LANES_RESET);
         awaited_results.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_results.size() == 0) begin
               $error("result item with no prediction waiting: kind %0d key 0x%0h",
                      rsp_tuser, rsp_tdata[31:0]);
               fail_count = fail_count + 1;
            end else begin
               want = awaited_results.pop_front();
               compare_field("kind", 64'(want.kind), 64'(rsp_tuser));
               compare_field("key_out", 64'(want.key), 64'(rsp_tdata[31:0]));
               compare_field("data_out", 64'(want.data), 64'(rsp_tdata[63:32]));
               compare_field("hit", 64'(want.hit), 64'(rsp_tdata[64]));
               compare_field("overflow", 64'(want.overflow), 64'(rsp_tdata[65]));
               compare_field("last", 64'(want.last), 64'(rsp_tlast));
            end
         end
         if (csr_valid && csr_ready) shadow_lanes = csr_data;
         if (req_tvalid && req_tready) begin
            apply_request(req_tuser, req_tdata[31:0], req_tdata[63:32]);
         end
      end
      outstanding <= awaited_results.size();
   end

endmodule

// ----- verif/tb_indexed_value_store_core.sv -----
// Testbench top of the indexed value store: stimulus, flow control and the verdict.
`timescale 1ns / 1ps
module tb_indexed_value_store_core;
   import ivs_pkg::*;

   localparam int POOL_SIZE     = 20;
   localparam int PHASES        = 8;
   localparam int PHASE_ITEMS   = 26;
   localparam int FILL_STORES   = 72;
   localparam int SETTLE_CYCLES = 40;
   localparam int LONG_HOLD     = 160;
   localparam int TIMEOUT_NS    = 5_000_000;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;  // index[31:0], value[63:32]
   logic [FUNC_W-1:0]      req_tuser  = FUNC_LOAD;  // func[1:0]
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;  // key_out[31:0], data_out[63:32], hit[64], overflow[65]
   logic [FUNC_W-1:0]      rsp_tuser;  // kind[1:0]
   logic                   rsp_tlast;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [LANES_W-1:0]     csr_data   = '0;

   int  fail_count;
   int  outstanding;
   int  idle_pct     = 0;
   bit  hold_request = 1'b0;
   bit  hold_served  = 1'b0;
   logic [KEY_W-1:0] key_pool [POOL_SIZE];

   // Lanes setting and idling rate of each mixed phase.
   int phase_lanes [PHASES] = '{1, 0, 31, 17, 5, 16, 3, 8};
   int phase_idle  [PHASES] = '{25, 0, 40, 15, 30, 0, 20, 35};

   indexed_value_store_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   ivs_result_checker result_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Offers one item, after a random gap if idling is on, and returns at its acceptance.
   task automatic send_item(input logic [FUNC_W-1:0] func, input logic [KEY_W-1:0] index,
                            input logic [DATA_W-1:0] value);
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {value, index};
      do @(posedge clock); while (!req_tready);
   endtask

   // Stops offering and waits until every predicted result has come, then lets the block settle.
   task automatic wait_quiet();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_lanes(input logic [LANES_W-1:0] lanes);
      wait_quiet();
      csr_valid <= 1'b1;
      csr_data  <= lanes;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Result receiver: random stalls, and one long hold-off that backs the block up.
   initial begin : result_sink
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (hold_request && !hold_served) begin
            hold_served = 1'b1;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin : stimulus
      int                i;
      int                p;
      int                r;
      int                done_items;
      logic [FUNC_W-1:0] func;
      logic [KEY_W-1:0]  index;
      logic [DATA_W-1:0] value;

      // Small set of keys reused often, so loads and stores keep hitting.
      for (i = 0; i < POOL_SIZE; i++) begin
         if (i < 6) key_pool[i] = KEY_W'(i);
         else if (i == 6) key_pool[i] = '1;
         else key_pool[i] = $urandom;
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty store: a load misses and an evict gives the single empty result.
      send_item(FUNC_LOAD, '0, '0);
      send_item(FUNC_EVICT, '0, '0);
      // Extreme keys and values, then hits, an update in place and a miss.
      send_item(FUNC_STORE, '0, '0);
      send_item(FUNC_STORE, '1, '1);
      send_item(FUNC_STORE, 32'h0000_0001, 32'h8000_0000);
      send_item(FUNC_LOAD, '0, '1);
      send_item(FUNC_LOAD, '1, '0);
      send_item(FUNC_LOAD, 32'h0000_0001, '0);
      send_item(FUNC_STORE, '0, 32'hA5A5_5A5A);
      send_item(FUNC_LOAD, '0, '0);
      send_item(FUNC_LOAD, 32'h5555_5555, '0);
      // The unused operation code is dropped without a result.
      send_item(FUNC_NOP, 32'hAAAA_AAAA, 32'h5555_5555);
      send_item(FUNC_LOAD, '0, '0);
      send_item(FUNC_EVICT, '0, '0);
      send_item(FUNC_LOAD, '1, '0);
      send_item(FUNC_EVICT, '0, '0);

      // One lane: an evict leaves a hole below a key that is then stored again.
      write_lanes(LANES_W'(1));
      send_item(FUNC_STORE, 32'd10, 32'd1);
      send_item(FUNC_STORE, 32'd20, 32'd2);
      send_item(FUNC_STORE, 32'd30, 32'd3);
      send_item(FUNC_EVICT, '0, '0);
      send_item(FUNC_STORE, 32'd30, 32'd99);
      send_item(FUNC_STORE, 32'd40, 32'd4);
      send_item(FUNC_LOAD, 32'd30, '0);
      send_item(FUNC_EVICT, '0, '0);
      send_item(FUNC_EVICT, '0, '0);

      // Mixed phases, each under its own lanes setting and idling rate.
      for (p = 0; p < PHASES; p++) begin
         write_lanes(LANES_W'(phase_lanes[p]));
         idle_pct = phase_idle[p];
         if (p == 2) hold_request = 1'b1;
         done_items = 0;
         while (done_items < PHASE_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 45) func = FUNC_STORE;
            else if (r < 80) func = FUNC_LOAD;
            else if (r < 92) func = FUNC_EVICT;
            else func = FUNC_NOP;
            r = $urandom_range(0, 99);
            if (r < 70) index = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            else if (r < 80) index = 32'h1 << $urandom_range(0, 31);
            else if (r < 85) index = ~(32'h1 << $urandom_range(0, 31));
            else index = $urandom;
            r = $urandom_range(0, 9);
            if (r == 0) value = '0;
            else if (r == 1) value = '1;
            else value = $urandom;
            send_item(func, index, value);
            if (func != FUNC_NOP) done_items++;
         end
      end

      // Fill the store past capacity with fresh keys; no idling from here on.
      write_lanes(LANES_W'(2));
      idle_pct = 0;
      for (i = 0; i < FILL_STORES; i++) begin
         send_item(FUNC_STORE, {8'hC3, 24'(i * 7 + 1)}, $urandom);
         if (i % 4 == 3) send_item(FUNC_LOAD, {8'hC3, 24'((i - 2) * 7 + 1)}, '0);
      end
      // A full store still updates a present key; a new key only keeps the flag set.
      send_item(FUNC_STORE, {8'hC3, 24'(1)}, 32'h0BAD_F00D);
      send_item(FUNC_LOAD, {8'hC3, 24'(1)}, '0);
      send_item(FUNC_STORE, 32'hC400_0000, $urandom);
      for (i = 0; i < 4; i++) send_item(FUNC_EVICT, '0, '0);
      for (i = 0; i < 3; i++) begin
         send_item(FUNC_STORE, {8'hC5, 24'(i)}, $urandom);
         send_item(FUNC_LOAD, {8'hC5, 24'(i)}, '0);
      end

      // Drain everything at the full lane count, ending on empty evicts.
      write_lanes(LANES_W'(16));
      for (i = 0; i < 6; i++) send_item(FUNC_EVICT, '0, '0);

      wait_quiet();
      if (fail_count == 0 && outstanding == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/ivs_pkg.sv
rtl/ivs_ram.sv
rtl/ivs_datapath.sv
rtl/ivs_ctrl.sv
rtl/indexed_value_store_core.sv
verif/ivs_result_checker.sv
verif/tb_indexed_value_store_core.sv
